/* rtl/olist_pkg.sv */
// Shared command codes, status codes and controller interface types of the ordered list engine.
package olist_pkg;

	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 8;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND       = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PREPEND      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT_AFTER = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE       = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_ALL     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_POSITION = 2'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic upd;     // apply an insert, or answer a command that changes nothing
		logic match;   // capture the per-cell compare for a delete
		logic del;     // close the gap at the first match and answer
		logic rd_clr;  // restart the read-out index
		logic rd;      // emit one element and rotate the chain
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic count_zero;
		logic rd_last;
	} stat_t;

endpackage

/* rtl/olist_ctrl.sv */
// Controller state machine of the ordered list engine.
module olist_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [olist_pkg::CMD_W-1:0] cmd,
	input  olist_pkg::stat_t           stat,
	output olist_pkg::ctrl_t           ctrl,
	output logic                       busy
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEL  = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd == olist_pkg::CMD_DELETE) begin
						ctrl.match = 1'b1;
						state_d    = S_DEL;
					end else if (cmd == olist_pkg::CMD_READ_ALL && !stat.count_zero) begin
						ctrl.rd_clr = 1'b1;
						state_d     = S_READ;
					end else begin
						ctrl.upd = 1'b1;
					end
				end
			end
			S_DEL: begin
				ctrl.del = 1'b1;
				state_d  = S_IDLE;
			end
			S_READ: begin
				ctrl.rd = 1'b1;
				if (stat.rd_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/olist_cells.sv */
// Datapath of the ordered list engine: shifting cell chain, count, read-out index and result register.
module olist_cells #(
	parameter int CAPACITY = 16,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  olist_pkg::ctrl_t                  ctrl,
	input  logic [olist_pkg::CMD_W-1:0]       cmd,
	input  logic signed [olist_pkg::VAL_W-1:0] value,
	input  logic [olist_pkg::POS_W-1:0]       position,
	output olist_pkg::stat_t                  stat,
	output logic                              result_valid,
	output logic [olist_pkg::ST_W-1:0]        status,
	output logic [CW-1:0]                     count,
	output logic signed [olist_pkg::VAL_W-1:0] element,
	output logic                              element_valid,
	output logic                              last
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CMPW = olist_pkg::POS_W + 1;

	logic signed [olist_pkg::VAL_W-1:0] cell_w [CAPACITY];
	logic signed [olist_pkg::VAL_W-1:0] prv_w  [CAPACITY];
	logic signed [olist_pkg::VAL_W-1:0] nxt_w  [CAPACITY];
	logic [CAPACITY-1:0] match_q;
	logic [CAPACITY-1:0] pfx;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       cnt_d;
	logic [CW-1:0]       cnt_m1;
	logic [IW-1:0]       rd_q;
	logic [IW-1:0]       ins_idx;
	logic [olist_pkg::ST_W-1:0] upd_st;
	logic                ins_ok;
	logic                ins_go;
	logic                del_go;
	logic                found;
	logic                is_ins;
	logic                full;

	assign cnt_m1 = cnt_q - CW'(1);
	assign found  = |match_q;
	assign full   = (cnt_q == CW'(CAPACITY));
	assign is_ins = (cmd == olist_pkg::CMD_APPEND) || (cmd == olist_pkg::CMD_PREPEND) ||
		(cmd == olist_pkg::CMD_INSERT_AFTER);

	assign stat.count_zero = (cnt_q == '0);
	assign stat.rd_last    = (CW'(rd_q) == cnt_m1);

	// Status of an update command and the slot where a new value lands.
	always_comb begin
		upd_st  = olist_pkg::ST_OK;
		ins_ok  = 1'b0;
		ins_idx = '0;
		if (is_ins) begin
			if (full) begin
				upd_st = olist_pkg::ST_FULL;
			end else if (cmd == olist_pkg::CMD_APPEND) begin
				ins_ok  = 1'b1;
				ins_idx = cnt_q[IW-1:0];
			end else if (cmd == olist_pkg::CMD_PREPEND) begin
				ins_ok = 1'b1;
			end else if ({1'b0, position} >= CMPW'(cnt_q)) begin
				upd_st = olist_pkg::ST_POSITION;
			end else begin
				ins_ok  = 1'b1;
				ins_idx = IW'({1'b0, position} + CMPW'(1));
			end
		end
	end

	assign ins_go = ctrl.upd & ins_ok;
	assign del_go = ctrl.del & found;

	always_comb begin
		cnt_d = cnt_q;
		if (ins_go) begin
			cnt_d = cnt_q + CW'(1);
		end else if (del_go) begin
			cnt_d = cnt_m1;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [olist_pkg::VAL_W-1:0] c_q;

		assign cell_w[i] = c_q;
		assign pfx[i]    = |match_q[i:0];

		if (i > 0) begin : g_prv
			assign prv_w[i] = cell_w[i-1];
		end else begin : g_prv0
			assign prv_w[i] = value;
		end

		if (i < CAPACITY - 1) begin : g_nxt
			assign nxt_w[i] = cell_w[i+1];
		end else begin : g_nxt_end
			assign nxt_w[i] = c_q;
		end

		always_ff @(posedge clk) begin
			if (ins_go) begin
				if (IW'(i) == ins_idx) begin
					c_q <= value;
				end else if (IW'(i) > ins_idx) begin
					c_q <= prv_w[i];
				end
			end else if (del_go) begin
				if (pfx[i]) begin
					c_q <= nxt_w[i];
				end
			end else if (ctrl.rd) begin
				if (CW'(i) == cnt_m1) begin
					c_q <= cell_w[0];
				end else begin
					c_q <= nxt_w[i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.match) begin
				match_q[i] <= (cell_w[i] == value) && (CW'(i) < cnt_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			rd_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			cnt_q        <= cnt_d;
			result_valid <= ctrl.upd | ctrl.del | ctrl.rd;
			if (ctrl.rd_clr) begin
				rd_q <= '0;
			end else if (ctrl.rd) begin
				rd_q <= rd_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd) begin
			status        <= olist_pkg::ST_OK;
			count         <= cnt_q;
			element       <= cell_w[0];
			element_valid <= 1'b1;
			last          <= stat.rd_last;
		end else if (ctrl.upd || ctrl.del) begin
			status        <= ctrl.del ? (found ? olist_pkg::ST_OK : olist_pkg::ST_NOTFOUND)
				: upd_st;
			count         <= cnt_d;
			element       <= '0;
			element_valid <= 1'b0;
			last          <= 1'b1;
		end
	end

endmodule

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine: a bounded ordered list of signed 32-bit values.
//
// A command beat (cmd, value, position) is taken at a rising edge where start is high and
// busy is low. Commands append, prepend, insert after a 0-based position, delete the first
// equal value, or read the whole list out in order.
// Results leave on status, count, element, element_valid and last, each beat valid for
// exactly one cycle while result_valid is high; the receiver cannot stall the block, so
// every beat must be taken as it appears.
// Append, prepend, insert-after, an unused code and a read of an empty list leave busy
// low; the single result beat shows in the cycle after the accepting edge and the next
// command may be taken in that same cycle.
// A delete first registers a compare of every cell against the value at the accepting
// edge, then closes the gap at the first match in the S_DEL state; its result follows that state.
// A read of N elements holds busy while they are emitted, one beat a cycle, with last
// on the final beat; the cell chain rotates once per beat and is back in order at the end.
// The storage is a chain of CAPACITY shifting cells, so an insert or delete moves every
// element at once; count is wide enough to hold CAPACITY.
// Reset clears the element count, the controller and the result strobe; cell contents are
// not cleared and are never read beyond the count.
module ordered_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [olist_pkg::CMD_W-1:0]        cmd,
	input  logic signed [olist_pkg::VAL_W-1:0] value,
	input  logic [olist_pkg::POS_W-1:0]        position,
	output logic                               result_valid,
	output logic [olist_pkg::ST_W-1:0]         status,
	output logic [$clog2(CAPACITY+1)-1:0]      count,
	output logic signed [olist_pkg::VAL_W-1:0] element,
	output logic                               element_valid,
	output logic                               last
);

	localparam int CW = $clog2(CAPACITY + 1);

	olist_pkg::ctrl_t ctrl;
	olist_pkg::stat_t stat;

	// The controller sequences each command; the cell chain does the data movement.
	olist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	olist_cells #(
		.CAPACITY (CAPACITY),
		.CW       (CW)
	) u_cells (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd           (cmd),
		.value         (value),
		.position      (position),
		.stat          (stat),
		.result_valid  (result_valid),
		.status        (status),
		.count         (count),
		.element       (element),
		.element_valid (element_valid),
		.last          (last)
	);

endmodule

/* rtl/olist_checker.sv */
// Port-level checks of the ordered list engine and their attachment to the top level.
module olist_checker #(
	parameter int CAPACITY = 16
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               result_valid,
	input logic [olist_pkg::ST_W-1:0]         status,
	input logic [$clog2(CAPACITY+1)-1:0]      count,
	input logic signed [olist_pkg::VAL_W-1:0] element,
	input logic                               element_valid,
	input logic                               last
);

	localparam int CW = $clog2(CAPACITY + 1);

	// A read-out runs without gaps until its final beat.
	a_readout_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("read-out beats not contiguous");

	// Only read-out beats may leave last low, and they carry an element.
	a_nonlast_has_element: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> element_valid)
		else $error("non-final beat without element");

	// Beats without an element are single-beat answers with a zero element.
	a_update_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !element_valid |-> last && element == '0)
		else $error("update beat malformed");

	// Element beats report success, and the count never exceeds the capacity.
	a_element_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> count <= CW'(CAPACITY) &&
		(!element_valid || status == olist_pkg::ST_OK))
		else $error("bad count or element status");

	// While a read-out still has beats to come, the block stays busy and takes no command.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy || $past(start))
		else $error("read-out in progress while idle");

endmodule

bind ordered_list_engine olist_checker #(
	.CAPACITY (CAPACITY)
) u_olist_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_valid  (result_valid),
	.status        (status),
	.count         (count),
	.element       (element),
	.element_valid (element_valid),
	.last          (last)
);
